// ----- design/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the stuffed frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned KIND_W           = 2;
  localparam int unsigned COUNT_W          = 7;
  localparam int unsigned BUFFER_BYTES_DEF = 64;

  localparam logic [BYTE_W-1:0] START_BYTE    = 8'h7E;
  localparam logic [BYTE_W-1:0] END_BYTE      = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_BYTE      = 8'h7F;
  localparam logic [BYTE_W-1:0] ESC_MASK      = 8'h7F;
  localparam logic [BYTE_W-1:0] STATION_RESET = 8'h01;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_CODE,
    PH_CODE_ESC,
    PH_DATA,
    PH_DATA_ESC
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA,
    KIND_GOOD,
    KIND_BAD,
    KIND_OVFL
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

// ----- design/sfr_byte_if.sv -----
// ----------------------------------------------------------------------------
// sfr_byte_if
// valid/ready channel carrying one received serial byte
// ----------------------------------------------------------------------------
interface sfr_byte_if;

  logic                      valid;
  logic                      ready;
  logic [sfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);

endinterface

// ----- design/sfr_result_if.sv -----
// ----------------------------------------------------------------------------
// sfr_result_if
// valid/ready channel carrying one deframer result word
// ----------------------------------------------------------------------------
interface sfr_result_if;

  logic                        valid;
  logic                        ready;
  logic [sfr_pkg::KIND_W-1:0]  kind;
  logic [sfr_pkg::BYTE_W-1:0]  value;
  logic [sfr_pkg::COUNT_W-1:0] count;

  modport source (output valid, output kind, output value, output count, input ready);
  modport sink   (input valid, input kind, input value, input count, output ready);

endinterface

// ----- design/sfr_in_stage.sv -----
// ----------------------------------------------------------------------------
// sfr_in_stage
// input register holding the next byte for the deframer
// ----------------------------------------------------------------------------
module sfr_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [sfr_pkg::BYTE_W-1:0] byte_i,
  input  logic                       take_i,
  output logic                       valid_o,
  output logic [sfr_pkg::BYTE_W-1:0] byte_o
);

  logic                       valid_q;
  logic [sfr_pkg::BYTE_W-1:0] byte_q;
  logic                       load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ----- design/sfr_deframe.sv -----
// ----------------------------------------------------------------------------
// sfr_deframe
// frame state machine, unescaping, byte count and checksum
// ----------------------------------------------------------------------------
module sfr_deframe #(
  parameter int unsigned BUFFER_BYTES = sfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [sfr_pkg::BYTE_W-1:0] byte_i,
  input  logic [sfr_pkg::BYTE_W-1:0] station_address_i,
  output logic                       res_valid_o,
  output sfr_pkg::result_t           res_o
);

  localparam int unsigned CntW = $clog2(BUFFER_BYTES);

  sfr_pkg::phase_e            phase_q, phase_d;
  logic [sfr_pkg::BYTE_W-1:0] code_q, code_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [sfr_pkg::BYTE_W-1:0] sum_q, sum_d;
  logic [sfr_pkg::BYTE_W-1:0] prev_q, prev_d;

  logic                       is_esc;
  logic                       is_end;
  logic                       is_data;
  logic                       is_frame_end;
  logic                       full;
  logic [sfr_pkg::BYTE_W-1:0] data_byte;
  logic [sfr_pkg::BYTE_W-1:0] expect_sum;
  logic [sfr_pkg::BYTE_W-1:0] got_sum;

  assign is_esc       = (byte_i == sfr_pkg::ESC_BYTE);
  assign is_end       = (byte_i == sfr_pkg::END_BYTE);
  assign is_data      = (phase_q == sfr_pkg::PH_DATA && !is_esc && !is_end)
                        || (phase_q == sfr_pkg::PH_DATA_ESC);
  assign is_frame_end = (phase_q == sfr_pkg::PH_DATA) && is_end;
  assign full         = (count_q == CntW'(BUFFER_BYTES - 1));
  assign data_byte    = (phase_q == sfr_pkg::PH_DATA_ESC) ? (byte_i & sfr_pkg::ESC_MASK)
                                                          : byte_i;
  assign expect_sum   = ~(station_address_i + code_q + sum_q);
  assign got_sum      = (count_q != '0 && count_q < CntW'(BUFFER_BYTES - 1)) ? prev_q
                                                                            : '0;

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      sfr_pkg::PH_HUNT: begin
        if (byte_i == sfr_pkg::START_BYTE) phase_d = sfr_pkg::PH_ADDR;
      end
      sfr_pkg::PH_ADDR:     phase_d = sfr_pkg::PH_CODE;
      sfr_pkg::PH_CODE: begin
        phase_d = is_esc ? sfr_pkg::PH_CODE_ESC : sfr_pkg::PH_DATA;
      end
      sfr_pkg::PH_CODE_ESC: phase_d = sfr_pkg::PH_DATA;
      sfr_pkg::PH_DATA: begin
        if (is_esc) begin
          phase_d = sfr_pkg::PH_DATA_ESC;
        end else if (is_end || full) begin
          phase_d = sfr_pkg::PH_HUNT;
        end
      end
      sfr_pkg::PH_DATA_ESC: begin
        phase_d = full ? sfr_pkg::PH_HUNT : sfr_pkg::PH_DATA;
      end
      default:              phase_d = sfr_pkg::PH_HUNT;
    endcase
  end

  // frame datapath
  always_comb begin
    code_d  = code_q;
    count_d = count_q;
    sum_d   = sum_q;
    prev_d  = prev_q;
    if (phase_q == sfr_pkg::PH_CODE) begin
      count_d = '0;
      sum_d   = '0;
      prev_d  = '0;
      if (!is_esc) code_d = byte_i;
    end else if (phase_q == sfr_pkg::PH_CODE_ESC) begin
      code_d = byte_i & sfr_pkg::ESC_MASK;
    end else if (is_data && !full) begin
      if (count_q != '0) sum_d = sum_q + prev_q;
      prev_d  = data_byte;
      count_d = count_q + CntW'(1);
    end
  end

  // result word
  always_comb begin
    res_valid_o = 1'b0;
    res_o.kind  = sfr_pkg::KIND_DATA;
    res_o.value = data_byte;
    res_o.count = sfr_pkg::COUNT_W'(count_q);
    if (is_data) begin
      res_valid_o = 1'b1;
      if (full) begin
        res_o.kind  = sfr_pkg::KIND_OVFL;
        res_o.value = code_q;
        res_o.count = sfr_pkg::COUNT_W'(BUFFER_BYTES);
      end
    end else if (is_frame_end) begin
      res_valid_o = 1'b1;
      res_o.kind  = (expect_sum == got_sum) ? sfr_pkg::KIND_GOOD : sfr_pkg::KIND_BAD;
      res_o.value = code_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfr_pkg::PH_HUNT;
      code_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
      prev_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      code_q  <= code_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      prev_q  <= prev_d;
    end
  end

  a_addr_then_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == sfr_pkg::PH_ADDR |=> phase_q == sfr_pkg::PH_CODE)
    else $error("address byte not followed by code phase");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(BUFFER_BYTES - 1))
    else $error("byte count beyond buffer");

  a_ovfl_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.kind == sfr_pkg::KIND_OVFL
    |=> phase_q == sfr_pkg::PH_HUNT)
    else $error("overflow did not return to hunting");

  a_data_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.kind == sfr_pkg::KIND_DATA
    |=> count_q == $past(count_q) + CntW'(1))
    else $error("data word did not advance byte count");

endmodule

// ----- design/sfr_out_stage.sv -----
// ----------------------------------------------------------------------------
// sfr_out_stage
// result register driving the output channel
// ----------------------------------------------------------------------------
module sfr_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  sfr_pkg::result_t res_i,
  output logic             space_o,
  sfr_result_if.source     res_o
);

  logic             valid_q;
  sfr_pkg::result_t res_q;

  assign space_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && space_o) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid = valid_q;
  assign res_o.kind  = res_q.kind;
  assign res_o.value = res_q.value;
  assign res_o.count = res_q.count;

endmodule

// ----- design/stuffed_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_unit
// byte-stuffed frame deframer with data words and checksum status per frame
// path: bytes pass the input register and deframer into the output register
// throughput: a byte per cycle unless res_o stalls (single-pass state update)
// reset: hunting for a start byte, frame state cleared, station address 1
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_unit #(
  parameter int unsigned BUFFER_BYTES = sfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sfr_pkg::BYTE_W-1:0] cfg_wdata_i,
  sfr_byte_if.sink                   rx_i,
  sfr_result_if.source               res_o
);

  logic [sfr_pkg::BYTE_W-1:0] station_q;
  logic                       in_valid;
  logic [sfr_pkg::BYTE_W-1:0] in_byte;
  logic                       step;
  logic                       res_valid;
  logic                       out_space;
  sfr_pkg::result_t           res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= sfr_pkg::STATION_RESET;
    end else if (cfg_we_i) begin
      station_q <= cfg_wdata_i;
    end
  end

  assign step = in_valid && (!res_valid || out_space);

  sfr_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_i.valid),
    .ready_o (rx_i.ready),
    .byte_i  (rx_i.rx_byte),
    .take_i  (step),
    .valid_o (in_valid),
    .byte_o  (in_byte)
  );

  sfr_deframe #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_deframe (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .byte_i            (in_byte),
    .station_address_i (station_q),
    .res_valid_o       (res_valid),
    .res_o             (res)
  );

  sfr_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .res_i   (res),
    .space_o (out_space),
    .res_o   (res_o)
  );

endmodule

// ----- bench/sfr_deframe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_deframe_checker
// follows the byte and result channels of the stuffed frame receiver, rebuilds
// the frame state from every accepted byte and checks each result word in order
// ----------------------------------------------------------------------------
module sfr_deframe_checker
  import sfr_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [BYTE_W-1:0]  cfg_wdata_i,
  input  logic               rx_valid_i,
  input  logic               rx_ready_i,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [KIND_W-1:0]  res_kind_i,
  input  logic [BYTE_W-1:0]  res_value_i,
  input  logic [COUNT_W-1:0] res_count_i,
  output int unsigned        errors_o,
  output int unsigned        outstanding_o
);

  phase_e            phase;
  logic [BYTE_W-1:0] station;
  logic [BYTE_W-1:0] frame_code;
  logic [BYTE_W-1:0] data_sum;
  logic [BYTE_W-1:0] last_data;
  int unsigned       n_data;
  result_t           expected_words[$];
  int unsigned       mismatches = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 40) begin
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  function automatic void store_data_byte(input logic [BYTE_W-1:0] d, output result_t word);
    word = '0;
    word.value = frame_code;
    if (n_data + 1 >= BUFFER_BYTES) begin
      // buffer full: overflow status instead of the data word
      word.kind  = KIND_OVFL;
      word.count = COUNT_W'(BUFFER_BYTES);
      phase      = PH_HUNT;
    end else begin
      if (n_data > 0) begin
        data_sum = data_sum + last_data;
      end
      last_data  = d;
      word.kind  = KIND_DATA;
      word.value = d;
      word.count = COUNT_W'(n_data);
      n_data++;
      phase = PH_DATA;
    end
  endfunction

  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t word);
    logic [BYTE_W-1:0] want_sum;
    logic [BYTE_W-1:0] got_sum;
    bit                has_word;
    has_word = 1'b0;
    word     = '0;
    case (phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          phase = PH_ADDR;
        end
      end
      PH_ADDR: phase = PH_CODE;
      PH_CODE: begin
        n_data    = 0;
        data_sum  = '0;
        last_data = '0;
        if (b == ESC_BYTE) begin
          phase = PH_CODE_ESC;
        end else begin
          frame_code = b;
          phase      = PH_DATA;
        end
      end
      PH_CODE_ESC: begin
        frame_code = b & ESC_MASK;
        phase      = PH_DATA;
      end
      PH_DATA: begin
        if (b == ESC_BYTE) begin
          phase = PH_DATA_ESC;
        end else if (b == END_BYTE) begin
          want_sum   = ~(station + frame_code + data_sum);
          got_sum    = (n_data > 0 && n_data < BUFFER_BYTES - 1) ? last_data : '0;
          word.kind  = (want_sum == got_sum) ? KIND_GOOD : KIND_BAD;
          word.value = frame_code;
          word.count = COUNT_W'(n_data);
          phase      = PH_HUNT;
          has_word   = 1'b1;
        end else begin
          store_data_byte(b, word);
          has_word = 1'b1;
        end
      end
      PH_DATA_ESC: begin
        store_data_byte(b & ESC_MASK, word);
        has_word = 1'b1;
      end
      default: phase = PH_HUNT;
    endcase
    return has_word;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t word;
    if (!rst_ni) begin
      phase      = PH_HUNT;
      station    = STATION_RESET;
      frame_code = '0;
      data_sum   = '0;
      last_data  = '0;
      n_data     = 0;
      expected_words.delete();
    end else begin
      if (cfg_we_i) begin
        station = cfg_wdata_i;
      end
      if (rx_valid_i && rx_ready_i) begin
        if (deframe_byte(rx_byte_i, word)) begin
          expected_words.push_back(word);
        end
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing pending, value", res_value_i, 0);
        end else begin
          word = expected_words.pop_front();
          if (res_kind_i !== word.kind) begin
            report_mismatch("kind", res_kind_i, word.kind);
          end
          if (res_value_i !== word.value) begin
            report_mismatch("value", res_value_i, word.value);
          end
          if (res_count_i !== word.count) begin
            report_mismatch("count", res_count_i, word.count);
          end
        end
      end
    end
    errors_o      <= mismatches;
    outstanding_o <= expected_words.size();
  end

endmodule

// ----- bench/stuffed_frame_receiver_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_unit_tb
// feeds hand-built and random byte-stuffed frames, noise and broken frames to
// the receiver under several station addresses with random stalls on both
// channels; the checker beside the block predicts and compares every word
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_unit_tb;

  import sfr_pkg::*;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t byte_q_t[$];

  localparam int unsigned BUF_BYTES    = BUFFER_BYTES_DEF;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned TARGET_BYTES = 1050;
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  byte_t       cfg_wdata;
  byte_t       station;
  bit          no_idle;
  bit          hold_req;
  int unsigned sent;
  int unsigned stall_cycles;
  int unsigned mismatch_total;
  int unsigned words_outstanding;

  sfr_byte_if   rx_if ();
  sfr_result_if res_if ();

  stuffed_frame_receiver_unit #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  sfr_deframe_checker #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .rx_valid_i   (rx_if.valid),
    .rx_ready_i   (rx_if.ready),
    .rx_byte_i    (rx_if.rx_byte),
    .res_valid_i  (res_if.valid),
    .res_ready_i  (res_if.ready),
    .res_kind_i   (res_if.kind),
    .res_value_i  (res_if.value),
    .res_count_i  (res_if.count),
    .errors_o     (mismatch_total),
    .outstanding_o(words_outstanding)
  );

  always #10 clk = ~clk;

  function automatic byte_t random_byte();
    case ($urandom_range(0, 11))
      0:       return START_BYTE;
      1:       return END_BYTE;
      2:       return ESC_BYTE;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input byte_t b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!(rx_if.valid && rx_if.ready));
    sent++;
  endtask

  // escape when required, and now and then when not, with a random top bit
  task automatic send_stuffed(input byte_t v, input bit must_escape);
    if (must_escape || (v < 8'h80 && $urandom_range(0, 7) == 0)) begin
      send_byte(ESC_BYTE);
      send_byte(v | ($urandom_range(0, 1) ? 8'h80 : 8'h00));
    end else begin
      send_byte(v);
    end
  endtask

  task automatic send_frame(input byte_t code, input byte_q_t body, input bit seal,
                            input bit close);
    byte_t sum;
    sum = station + code;
    foreach (body[i]) sum = sum + body[i];
    if (seal) begin
      body.push_back(~sum);
    end
    send_byte(START_BYTE);
    send_byte(random_byte());
    send_stuffed(code, code == ESC_BYTE);
    foreach (body[i]) send_stuffed(body[i], body[i] == ESC_BYTE || body[i] == END_BYTE);
    if (close) begin
      send_byte(END_BYTE);
    end
  endtask

  task automatic send_random_item();
    int unsigned pick;
    int unsigned len;
    byte_q_t     body;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(random_byte());
    end else begin
      if (pick < 14) begin
        len = $urandom_range(60, 70);
      end else if (pick < 20) begin
        len = 0;
      end else begin
        len = $urandom_range(1, 12);
      end
      repeat (len) body.push_back(random_byte());
      send_frame(random_byte(), body, $urandom_range(0, 4) != 0, $urandom_range(0, 19) != 0);
    end
  endtask

  task automatic settle();
    rx_if.valid <= 1'b0;
    do @(posedge clk); while (words_outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_station(input byte_t v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    station = v;
  endtask

  // result side
  initial begin
    int unsigned gap;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
          res_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("stuffed_frame_receiver_unit_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    byte_t csum;
    byte_t next_station;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    station  = STATION_RESET;
    no_idle  = 1'b0;
    hold_req = 1'b0;
    sent     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // noise while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    // end byte as code, empty frame
    send_byte(START_BYTE);
    send_byte(8'hFF);
    send_byte(END_BYTE);
    send_byte(END_BYTE);
    // escaped code, escaped end byte as data, start byte inside the frame
    csum = ~(station + (START_BYTE & ESC_MASK) + END_BYTE + START_BYTE);
    send_byte(START_BYTE);
    send_byte(8'h00);
    send_byte(ESC_BYTE);
    send_byte(START_BYTE | 8'h80);
    send_byte(ESC_BYTE);
    send_byte(END_BYTE);
    send_byte(START_BYTE);
    send_byte(csum);
    send_byte(END_BYTE);
    // one data byte that is its own matching checksum
    send_byte(START_BYTE);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(END_BYTE);
    // checksum mismatch
    send_byte(START_BYTE);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(END_BYTE);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1:       next_station = 8'h00;
          2:       next_station = 8'hFF;
          3:       next_station = 8'h80;
          4:       next_station = 8'h7F;
          default: next_station = byte_t'($urandom_range(0, 255));
        endcase
        write_station(next_station);
      end
      no_idle = (p == 2 || p == 4);
      if (p == 2) begin
        hold_req = 1'b1;
      end
      while (sent < (p + 1) * TARGET_BYTES / NUM_PHASES) send_random_item();
    end

    settle();
    if (mismatch_total == 0) begin
      $display("stuffed_frame_receiver_unit_tb passed");
    end else begin
      $display("stuffed_frame_receiver_unit_tb failed");
    end
    $finish;
  end

endmodule
